[rtl/rope_pkg.sv]
`default_nettype none

package rope_pkg;

  localparam int unsigned MAX_HEAD_SIZE_DEF = 256;
  localparam int unsigned POS_LIMIT_DEF     = 32768;

  localparam int unsigned VAL_W     = 25;
  localparam int unsigned HS_W      = 9;
  localparam int unsigned LB_W      = 22;
  localparam int unsigned IDX_W     = 7;
  localparam int unsigned POS_W     = 15;
  localparam int unsigned CFG_W     = 22;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [HS_W-1:0] HS_RESET = 9'd128;
  localparam logic [LB_W-1:0] LB_RESET = 22'd870823;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HEAD_SIZE = 1'b0,
    CFG_LOG2_BASE = 1'b1
  } cfg_reg_e;

  // exponent width: log2_base * 2 * pair_index
  localparam int unsigned E_W        = LB_W + 1 + IDX_W;
  localparam int unsigned DIV_BITS   = 3;
  localparam int unsigned DIV_STAGES = E_W / DIV_BITS;
  localparam int unsigned FRAC_W     = 16;
  localparam int unsigned MANT_W     = 31;
  localparam int unsigned TURN_W     = 39;
  localparam int unsigned XY_W       = 33;
  localparam int unsigned Z_W        = 34;
  localparam int unsigned STEPS      = 16;

  localparam logic [29:0]            TURN_SCALE  = 30'd683565276;
  localparam logic signed [XY_W-1:0] CORDIC_GAIN = 33'sd652032874;

  function automatic logic [63:0] rope_isqrt(input logic [63:0] v);
    logic [63:0] rem;
    logic [63:0] res;
    logic [63:0] b;
    rem = v;
    res = '0;
    b   = 64'h4000_0000_0000_0000;
    for (int i = 0; i < 32; i++) begin
      if (rem >= res + b) begin
        rem = rem - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // Q30 value of 2^(-2^-k)
  function automatic logic [29:0] rope_root(input int k);
    logic [63:0] c;
    c = 64'd1 << 29;
    for (int j = 1; j <= k; j++) begin
      c = rope_isqrt(c << 30);
    end
    return c[29:0];
  endfunction

  // arctangent of 2^-k in Q32 turns
  function automatic logic signed [Z_W-1:0] rope_atan(input int k);
    logic signed [Z_W-1:0] a;
    unique case (k)
      0:       a = 34'sh0_2000_0000;
      1:       a = 34'sh0_12E4_051E;
      2:       a = 34'sh0_09FB_385B;
      3:       a = 34'sh0_0511_11D4;
      4:       a = 34'sh0_028B_0D43;
      5:       a = 34'sh0_0145_D7E1;
      6:       a = 34'sh0_00A2_F61E;
      7:       a = 34'sh0_0051_7C55;
      8:       a = 34'sh0_0028_BE53;
      9:       a = 34'sh0_0014_5F2F;
      10:      a = 34'sh0_000A_2F98;
      11:      a = 34'sh0_0005_17CC;
      12:      a = 34'sh0_0002_8BE6;
      13:      a = 34'sh0_0001_45F3;
      14:      a = 34'sh0_0000_A2F9;
      15:      a = 34'sh0_0000_517D;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

`default_nettype wire

[rtl/rotary_position_embedding.sv]
// Rotary position embedding, half-split pair rotation, signed Q8.16.
//
// Input channel (in_valid_i / in_ready_o): one element pair per transfer,
// with its pair index, token position and an end-of-row mark.
// Output channel (out_valid_o / out_ready_i): the rotated pair, saturated to
// Q8.16, with the end-of-row mark copied.
// Configuration: cfg_we_i writes head_size (index 0) or log2_base (index 1)
// from cfg_data_i in the same cycle; write only while the pipe is empty.
//
// Throughput: one pair per cycle unless the receiver stalls. The pipe has
// 49 stages: an input register, a 10-stage radix-8 divider for the exponent,
// 16 conditional-multiply stages for the power of two, frequency, turn, phase
// and fold registers, 16 CORDIC stages, a product stage and a round stage.
//
// Reset clears all valid bits and loads head_size 128, log2_base 870823.
// When the receiver stalls with a result waiting, the whole pipe holds and
// in_ready_o drops; nothing is lost or repeated.
`default_nettype none

module rotary_position_embedding
  import rope_pkg::*;
#(
  parameter int unsigned MAX_HEAD_SIZE = MAX_HEAD_SIZE_DEF,
  parameter int unsigned POS_LIMIT     = POS_LIMIT_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]        cfg_idx_i,
  input  wire logic [CFG_W-1:0]            cfg_data_i,
  input  wire logic                        in_valid_i,
  output      logic                        in_ready_o,
  input  wire logic signed [VAL_W-1:0]     first_value_i,
  input  wire logic signed [VAL_W-1:0]     second_value_i,
  input  wire logic [IDX_W-1:0]            pair_index_i,
  input  wire logic [POS_W-1:0]            position_i,
  input  wire logic                        last_in_i,
  output      logic                        out_valid_o,
  input  wire logic                        out_ready_i,
  output      logic signed [VAL_W-1:0]     first_result_o,
  output      logic signed [VAL_W-1:0]     second_result_o,
  output      logic                        last_out_o
);

  localparam int unsigned ST_MANT0 = DIV_STAGES + 1;
  localparam int unsigned ST_SHF   = ST_MANT0 + FRAC_W;
  localparam int unsigned ST_TRN   = ST_SHF + 1;
  localparam int unsigned ST_PHS   = ST_TRN + 1;
  localparam int unsigned ST_FLD   = ST_PHS + 1;
  localparam int unsigned ST_COR0  = ST_FLD + 1;
  localparam int unsigned ST_MUL   = ST_COR0 + STEPS;
  localparam int unsigned ST_OUT   = ST_MUL + 1;
  localparam int unsigned NST      = ST_OUT + 1;

  // configuration
  logic [HS_W-1:0] head_size_q;
  logic [LB_W-1:0] log2_base_q;
  logic [HS_W-1:0] hs_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_size_q <= HS_RESET;
      log2_base_q <= LB_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_HEAD_SIZE: head_size_q <= cfg_data_i[HS_W-1:0];
        CFG_LOG2_BASE: log2_base_q <= cfg_data_i[LB_W-1:0];
        default:       ;
      endcase
    end
  end

  always_comb begin
    if (head_size_q < HS_W'(2)) begin
      hs_eff = HS_W'(2);
    end else if (32'(head_size_q) > MAX_HEAD_SIZE) begin
      hs_eff = HS_W'(MAX_HEAD_SIZE);
    end else begin
      hs_eff = head_size_q;
    end
  end

  // pipe control
  logic en;
  logic vld_q [NST];

  assign en          = !vld_q[NST-1] || out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = vld_q[NST-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < NST; s++) begin
        vld_q[s] <= 1'b0;
      end
    end else if (en) begin
      vld_q[0] <= in_valid_i;
      for (int s = 1; s < NST; s++) begin
        vld_q[s] <= vld_q[s-1];
      end
    end
  end

  // side-band carried along the pipe
  logic signed [VAL_W-1:0] v0_q   [ST_MUL];
  logic signed [VAL_W-1:0] v1_q   [ST_MUL];
  logic [POS_W-1:0]        pos_q  [ST_PHS];
  logic                    last_q [NST];

  logic [POS_W-1:0] pos_clamp;
  logic [E_W-1:0]   dividend;

  always_comb begin
    if (32'(position_i) >= POS_LIMIT) begin
      pos_clamp = POS_W'(POS_LIMIT - 1);
    end else begin
      pos_clamp = position_i;
    end
  end

  assign dividend = E_W'({log2_base_q, 1'b0}) * E_W'(pair_index_i);

  // divider state
  logic [HS_W-1:0] div_rem_q [DIV_STAGES+1];
  logic [E_W-1:0]  div_dq_q  [DIV_STAGES+1];

  always_ff @(posedge clk_i) begin
    if (en) begin
      v0_q[0]      <= first_value_i;
      v1_q[0]      <= second_value_i;
      pos_q[0]     <= pos_clamp;
      last_q[0]    <= last_in_i;
      div_rem_q[0] <= '0;
      div_dq_q[0]  <= dividend;
    end
  end

  for (genvar s = 1; s < NST; s++) begin : g_side
    always_ff @(posedge clk_i) begin
      if (en) begin
        last_q[s] <= last_q[s-1];
      end
    end
    if (s < ST_MUL) begin : g_val
      always_ff @(posedge clk_i) begin
        if (en) begin
          v0_q[s] <= v0_q[s-1];
          v1_q[s] <= v1_q[s-1];
        end
      end
    end
    if (s < ST_PHS) begin : g_pos
      always_ff @(posedge clk_i) begin
        if (en) begin
          pos_q[s] <= pos_q[s-1];
        end
      end
    end
  end

  // exponent = dividend / hs_eff, three quotient bits per stage
  for (genvar d = 0; d < DIV_STAGES; d++) begin : g_div
    logic [HS_W-1:0] rem_d;
    logic [E_W-1:0]  dq_d;

    always_comb begin : p_step
      logic [HS_W-1:0] r;
      logic [E_W-1:0]  q;
      logic [HS_W:0]   t;
      r = div_rem_q[d];
      q = div_dq_q[d];
      for (int b = 0; b < DIV_BITS; b++) begin
        t = {r, q[E_W-1]};
        q = {q[E_W-2:0], 1'b0};
        if (t >= {1'b0, hs_eff}) begin
          t    = t - {1'b0, hs_eff};
          q[0] = 1'b1;
        end
        r = t[HS_W-1:0];
      end
      rem_d = r;
      dq_d  = q;
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        div_rem_q[d+1] <= rem_d;
        div_dq_q[d+1]  <= dq_d;
      end
    end
  end

  // 2^-frac mantissa, one fraction bit per stage
  logic [MANT_W-1:0] mant_q [FRAC_W];
  logic [E_W-1:0]    e_q    [FRAC_W];

  for (genvar k = 0; k < FRAC_W; k++) begin : g_mant
    localparam logic [29:0] CK = rope_root(k + 1);
    logic [MANT_W-1:0]    m_in;
    logic [E_W-1:0]       e_in;
    logic [MANT_W+29:0]   prod;

    if (k == 0) begin : g_first
      assign m_in = MANT_W'(1) << 30;
      assign e_in = div_dq_q[DIV_STAGES];
    end else begin : g_next
      assign m_in = mant_q[k-1];
      assign e_in = e_q[k-1];
    end

    assign prod = (MANT_W+30)'(m_in) * (MANT_W+30)'(CK);

    always_ff @(posedge clk_i) begin
      if (en) begin
        e_q[k]    <= e_in;
        mant_q[k] <= e_in[FRAC_W-1-k] ? prod[MANT_W+29:30] : m_in;
      end
    end
  end

  // frequency, turns, phase
  logic [MANT_W-1:0]      freq_q;
  logic [TURN_W-1:0]      fturn_q;
  logic [31:0]            phase_q;
  logic [E_W-FRAC_W-1:0]  ipart;
  logic [MANT_W+29:0]     turn_prod;
  logic [POS_W+TURN_W-1:0] phase_prod;

  assign ipart      = e_q[FRAC_W-1][E_W-1:FRAC_W];
  assign turn_prod  = (MANT_W+30)'(freq_q) * (MANT_W+30)'(TURN_SCALE);
  assign phase_prod = (POS_W+TURN_W)'(pos_q[ST_PHS-1]) * (POS_W+TURN_W)'(fturn_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      freq_q  <= (ipart < (E_W-FRAC_W)'(31)) ? (mant_q[FRAC_W-1] >> ipart[4:0]) : '0;
      fturn_q <= turn_prod[TURN_W+21:22];
      phase_q <= phase_prod[39:8];
    end
  end

  // fold phase into [-1/4, 1/4] turn
  logic signed [XY_W-1:0] cx_q   [STEPS];
  logic signed [XY_W-1:0] cy_q   [STEPS];
  logic signed [Z_W-1:0]  cz_q   [STEPS+1];
  logic                   flip_q [STEPS+1];
  logic signed [Z_W-1:0]  z_raw;
  logic signed [Z_W-1:0]  z_fold;
  logic                   flip_d;

  assign z_raw = Z_W'($signed(phase_q));

  always_comb begin
    z_fold = z_raw;
    flip_d = 1'b0;
    if (z_raw > 34'sd1073741824) begin
      z_fold = z_raw - 34'sd2147483648;
      flip_d = 1'b1;
    end else if (z_raw < -34'sd1073741824) begin
      z_fold = z_raw + 34'sd2147483648;
      flip_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      cz_q[0]   <= z_fold;
      flip_q[0] <= flip_d;
    end
  end

  // CORDIC rotation, one iteration per stage
  for (genvar k = 0; k < STEPS; k++) begin : g_cor
    localparam logic signed [Z_W-1:0] ATAN = rope_atan(k);
    logic signed [XY_W-1:0] x_in;
    logic signed [XY_W-1:0] y_in;
    logic signed [XY_W-1:0] dx;
    logic signed [XY_W-1:0] dy;

    if (k == 0) begin : g_first
      assign x_in = CORDIC_GAIN;
      assign y_in = '0;
    end else begin : g_next
      assign x_in = cx_q[k-1];
      assign y_in = cy_q[k-1];
    end

    assign dx = y_in >>> k;
    assign dy = x_in >>> k;

    always_ff @(posedge clk_i) begin
      if (en) begin
        flip_q[k+1] <= flip_q[k];
        if (!cz_q[k][Z_W-1]) begin
          cx_q[k]   <= x_in - dx;
          cy_q[k]   <= y_in + dy;
          cz_q[k+1] <= cz_q[k] - ATAN;
        end else begin
          cx_q[k]   <= x_in + dx;
          cy_q[k]   <= y_in - dy;
          cz_q[k+1] <= cz_q[k] + ATAN;
        end
      end
    end
  end

  // products, then sum, round and saturate
  localparam int unsigned P_W = VAL_W + XY_W;
  localparam int unsigned S_W = P_W + 2;

  logic signed [P_W-1:0] p0_q, p1_q, p2_q, p3_q;
  logic                  mflip_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      p0_q    <= v0_q[ST_MUL-1] * cx_q[STEPS-1];
      p1_q    <= v1_q[ST_MUL-1] * cy_q[STEPS-1];
      p2_q    <= v0_q[ST_MUL-1] * cy_q[STEPS-1];
      p3_q    <= v1_q[ST_MUL-1] * cx_q[STEPS-1];
      mflip_q <= flip_q[STEPS];
    end
  end

  function automatic logic signed [VAL_W-1:0] rope_sat(input logic signed [S_W-1:0] s);
    logic signed [S_W-1:0] r;
    logic signed [VAL_W-1:0] o;
    r = (s + S_W'(64'sd536870912)) >>> 30;
    if (r > S_W'(64'sd16777215)) begin
      o = 25'sd16777215;
    end else if (r < -S_W'(64'sd16777216)) begin
      o = -25'sd16777216;
    end else begin
      o = r[VAL_W-1:0];
    end
    return o;
  endfunction

  logic signed [S_W-1:0]   sum0;
  logic signed [S_W-1:0]   sum1;
  logic signed [VAL_W-1:0] res0_q;
  logic signed [VAL_W-1:0] res1_q;

  assign sum0 = mflip_q ? (S_W'(p1_q) - S_W'(p0_q)) : (S_W'(p0_q) - S_W'(p1_q));
  assign sum1 = mflip_q ? -(S_W'(p2_q) + S_W'(p3_q)) : (S_W'(p2_q) + S_W'(p3_q));

  always_ff @(posedge clk_i) begin
    if (en) begin
      res0_q <= rope_sat(sum0);
      res1_q <= rope_sat(sum1);
    end
  end

  assign first_result_o  = res0_q;
  assign second_result_o = res1_q;
  assign last_out_o      = last_q[NST-1];

endmodule

`default_nettype wire

[rtl/rope_checker.sv]
`default_nettype none

module rope_checker
  import rope_pkg::*;
(
  input wire logic                    clk_i,
  input wire logic                    rst_ni,
  input wire logic                    in_ready_o,
  input wire logic                    out_valid_o,
  input wire logic                    out_ready_i,
  input wire logic signed [VAL_W-1:0] first_result_o,
  input wire logic signed [VAL_W-1:0] second_result_o,
  input wire logic                    last_out_o
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(first_result_o)
      && $stable(second_result_o) && $stable(last_out_o))
    else $error("stalled result changed");

  // a waiting result stops new transfers
  a_stall_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !in_ready_o)
    else $error("input taken while output stalled");

  // output transfer or an empty output stage frees the pipe
  a_drain_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_o || out_ready_i) |-> in_ready_o)
    else $error("pipe blocked without a stall");

endmodule

bind rotary_position_embedding rope_checker u_rope_checker (.*);

`default_nettype wire

[test/rope_checker.sv]
`timescale 1ns / 100ps

module rope_scoreboard
  import rope_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [CFG_W-1:0]        cfg_data_i,
  input  logic                    in_valid_i,
  input  logic                    in_ready_i,
  input  logic signed [VAL_W-1:0] first_value_i,
  input  logic signed [VAL_W-1:0] second_value_i,
  input  logic [IDX_W-1:0]        pair_index_i,
  input  logic [POS_W-1:0]        position_i,
  input  logic                    last_in_i,
  input  logic                    out_valid_i,
  input  logic                    out_ready_i,
  input  logic signed [VAL_W-1:0] first_result_i,
  input  logic signed [VAL_W-1:0] second_result_i,
  input  logic                    last_out_i,
  output int                      fail_count_o,
  output int                      pending_o
);

  typedef struct packed {
    logic signed [VAL_W-1:0] first;
    logic signed [VAL_W-1:0] second;
    logic                    last;
  } rotated_pair_t;

  rotated_pair_t rotated_q[$];
  logic [HS_W-1:0] head_size_q;
  logic [LB_W-1:0] log2_base_q;
  longint atan_tab [16];
  longint unsigned root_tab [17];

  initial begin
    longint unsigned c;
    atan_tab = '{64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
                 64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
                 64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
                 64'h00028BE6, 64'h000145F3, 64'h0000A2F9, 64'h0000517D};
    c = 64'd1 << 29;
    for (int k = 1; k <= 16; k++) begin
      c = square_root(c << 30);
      root_tab[k] = c;
    end
  end

  function automatic longint unsigned square_root(longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic logic signed [VAL_W-1:0] round_saturate(longint acc);
    longint r;
    r = (acc + (64'sd1 << 29)) >>> 30;
    if (r > 16777215) r = 16777215;
    if (r < -16777216) r = -16777216;
    return r[VAL_W-1:0];
  endfunction

  function automatic rotated_pair_t rotate_pair(longint v0, longint v1,
                                                longint unsigned idx,
                                                longint unsigned pos, logic last);
    longint unsigned hs, e, ipart, frac, mant, freq, fturn, phase;
    longint z, x, y, dx, dy;
    logic flip;
    rotated_pair_t r;
    hs = head_size_q;
    if (hs < 2) hs = 2;
    if (hs > 256) hs = 256;
    e = (longint'(log2_base_q) * 2 * idx) / hs;
    ipart = e >> 16;
    frac = e & 64'hFFFF;
    mant = 64'd1 << 30;
    for (int k = 1; k <= 16; k++)
      if ((frac >> (16 - k)) & 1) mant = (mant * root_tab[k]) >> 30;
    freq = (ipart < 31) ? (mant >> ipart) : 0;
    fturn = (freq * 64'd683565276) >> 22;
    phase = ((pos * fturn) >> 8) & 64'hFFFFFFFF;
    z = (phase >= 64'h80000000) ? longint'(phase) - (64'sd1 << 32) : longint'(phase);
    flip = 0;
    if (z > (64'sd1 << 30)) begin
      z -= 64'sd1 << 31;
      flip = 1;
    end else if (z < -(64'sd1 << 30)) begin
      z += 64'sd1 << 31;
      flip = 1;
    end
    x = 652032874;
    y = 0;
    for (int k = 0; k < 16; k++) begin
      dx = y >>> k;
      dy = x >>> k;
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_tab[k];
      end else begin
        x += dx; y -= dy; z += atan_tab[k];
      end
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    r.first = round_saturate(v0 * x - v1 * y);
    r.second = round_saturate(v0 * y + v1 * x);
    r.last = last;
    return r;
  endfunction

  assign pending_o = rotated_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    rotated_pair_t exp_r;
    if (!rst_ni) begin
      head_size_q <= HS_RESET;
      log2_base_q <= LB_RESET;
      fail_count_o <= 0;
      rotated_q.delete();
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_HEAD_SIZE) head_size_q <= cfg_data_i[HS_W-1:0];
        else log2_base_q <= cfg_data_i[LB_W-1:0];
      end
      if (in_valid_i && in_ready_i)
        rotated_q.push_back(rotate_pair(first_value_i, second_value_i, pair_index_i,
                                        position_i, last_in_i));
      if (out_valid_i && out_ready_i) begin
        if (rotated_q.size() == 0) begin
          fail_count_o <= fail_count_o + 1;
          if (fail_count_o < 10) $display("unexpected result transfer at %0t", $time);
        end else begin
          exp_r = rotated_q.pop_front();
          if (exp_r.first !== first_result_i || exp_r.second !== second_result_i ||
              exp_r.last !== last_out_i) begin
            fail_count_o <= fail_count_o + 1;
            if (fail_count_o < 10)
              $display("mismatch at %0t: exp %0d %0d %0b got %0d %0d %0b", $time,
                       exp_r.first, exp_r.second, exp_r.last,
                       first_result_i, second_result_i, last_out_i);
          end
        end
      end
    end
  end

endmodule

[test/tb_rotary_position_embedding.sv]
`timescale 1ns / 100ps

module tb_rotary_position_embedding;
  import rope_pkg::*;

  logic clk_i = 0;
  logic rst_ni = 0;
  logic cfg_we_i = 0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = CFG_HEAD_SIZE;
  logic [CFG_W-1:0] cfg_data_i = '0;
  logic in_valid_i = 0;
  logic in_ready_o;
  logic signed [VAL_W-1:0] first_value_i = '0;
  logic signed [VAL_W-1:0] second_value_i = '0;
  logic [IDX_W-1:0] pair_index_i = '0;
  logic [POS_W-1:0] position_i = '0;
  logic last_in_i = 0;
  logic out_valid_o;
  logic out_ready_i = 0;
  logic signed [VAL_W-1:0] first_result_o, second_result_o;
  logic last_out_o;
  int fail_count, pending_rotations;
  bit stimulus_done = 0;

  always begin
    #5 clk_i = 1;
    #5 clk_i = 0;
  end

  rotary_position_embedding dut (.*);

  rope_scoreboard u_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_ready_i(in_ready_o), .first_value_i, .second_value_i,
    .pair_index_i, .position_i, .last_in_i,
    .out_valid_i(out_valid_o), .out_ready_i, .first_result_i(first_result_o),
    .second_result_i(second_result_o), .last_out_i(last_out_o),
    .fail_count_o(fail_count), .pending_o(pending_rotations)
  );

  // receiver stall pattern
  int stall_mode = 0;
  always @(posedge clk_i) begin
    if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: out_ready_i <= 1'b1;
      1: out_ready_i <= $urandom_range(0, 3) != 0;
      2: out_ready_i <= $urandom_range(0, 1);
      default: out_ready_i <= $urandom_range(0, 7) == 0;
    endcase
  end

  int gap_left = 0;
  int burst_left = 0;

  task automatic send_pair(logic signed [VAL_W-1:0] v0, logic signed [VAL_W-1:0] v1,
                           logic [IDX_W-1:0] idx, logic [POS_W-1:0] pos, logic last);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 12);
    end
    while (gap_left > 0) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
      gap_left--;
    end
    in_valid_i <= 1'b1;
    first_value_i <= v0;
    second_value_i <= v1;
    pair_index_i <= idx;
    position_i <= pos;
    last_in_i <= last;
    do @(posedge clk_i); while (!in_ready_o);
    burst_left--;
  endtask

  task automatic drain_pipe();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_rotations != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [CFG_W-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic signed [VAL_W-1:0] random_value();
    case ($urandom_range(0, 5))
      0: return -25'sd16777216;
      1: return 25'sd16777215;
      2: return $signed(25'($urandom_range(0, 255)) - 25'd128);
      default: return 25'($urandom);
    endcase
  endfunction

  task automatic random_rows(int count, int hs);
    int half;
    logic [POS_W-1:0] pos;
    half = (hs < 2) ? 1 : (hs > 256 ? 128 : hs / 2);
    if (half > 128) half = 128;
    while (count > 0) begin
      pos = ($urandom_range(0, 3) == 0) ? 15'($urandom) : 15'($urandom_range(0, 2048));
      if ($urandom_range(0, 9) == 0) begin
        send_pair(random_value(), random_value(), 7'($urandom), 15'($urandom),
                  1'($urandom));
        count--;
      end else begin
        for (int i = 0; i < half && count > 0; i++) begin
          send_pair(random_value(), random_value(), 7'(i), pos, i == half - 1);
          count--;
        end
      end
    end
  endtask

  initial begin
    int head_sizes [6];
    int bases [6];
    head_sizes = '{128, 2, 256, 511, 7, 64};
    bases = '{870823, 0, 4194303, 870823, 1000000, 600000};
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // directed: field extremes and simple values at reset settings
    send_pair(25'sd16777215, 25'sd16777215, 7'd0, 15'd0, 1'b0);
    send_pair(-25'sd16777216, -25'sd16777216, 7'd127, 15'd32767, 1'b1);
    send_pair(-25'sd16777216, 25'sd16777215, 7'd1, 15'd32767, 1'b0);
    send_pair(25'sd16777215, -25'sd16777216, 7'd63, 15'd1, 1'b1);
    send_pair(25'sd65536, 25'sd0, 7'd0, 15'd12345, 1'b0);
    send_pair(25'sd0, 25'sd65536, 7'd64, 15'd100, 1'b0);
    send_pair(25'sd0, 25'sd0, 7'd5, 15'd7, 1'b1);
    send_pair(25'sd1, -25'sd1, 7'd127, 15'd0, 1'b0);
    drain_pipe();
    for (int p = 0; p < 6; p++) begin
      write_reg(CFG_HEAD_SIZE, CFG_W'(head_sizes[p]));
      write_reg(CFG_LOG2_BASE, CFG_W'(bases[p]));
      if (p == 0) begin
        write_reg(CFG_HEAD_SIZE, CFG_W'(0));
        send_pair(25'sd16777215, 25'sd12345, 7'd1, 15'd32767, 1'b1);
        send_pair(25'sd65536, 25'sd65536, 7'd127, 15'd32767, 1'b0);
        drain_pipe();
        write_reg(CFG_HEAD_SIZE, CFG_W'(1));
        write_reg(CFG_LOG2_BASE, CFG_W'(4194303));
        send_pair(25'sd65536, 25'sd65536, 7'd127, 15'd32767, 1'b1);
        send_pair(25'sd65536, 25'sd65536, 7'd1, 15'd32767, 1'b0);
        drain_pipe();
        write_reg(CFG_HEAD_SIZE, CFG_W'(head_sizes[p]));
        write_reg(CFG_LOG2_BASE, CFG_W'(bases[p]));
      end
      random_rows(290, head_sizes[p]);
      drain_pipe();
    end
    stimulus_done = 1;
  end

  initial begin
    wait (stimulus_done);
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
